[hw/rtl/dna_pkg.sv]
package dna_pkg;

    localparam int WordBits = 32;
    localparam int FracBits = 16;
    localparam int ExpBits  = 16;

    typedef logic signed [WordBits-1:0] word_t;

    // operation codes carried in func
    typedef enum logic [2:0] {
        FUNC_ADD   = 3'd0,
        FUNC_ADDC  = 3'd1,
        FUNC_SUB   = 3'd2,
        FUNC_MUL   = 3'd3,
        FUNC_MULC  = 3'd4,
        FUNC_DIV   = 3'd5,
        FUNC_CDIV  = 3'd6,
        FUNC_POW   = 3'd7
    } func_t;

    typedef struct packed {
        logic [2:0]                 func;
        logic signed [WordBits-1:0] f_value;
        logic signed [WordBits-1:0] f_deriv;
        logic signed [WordBits-1:0] g_value;
        logic signed [WordBits-1:0] g_deriv;
        logic signed [WordBits-1:0] const_in;
        logic signed [ExpBits-1:0]  exponent;
    } in_item_t;

    typedef struct packed {
        logic signed [WordBits-1:0] res_value;
        logic signed [WordBits-1:0] res_deriv;
        logic                       overflow;
        logic                       div_zero;
    } out_item_t;

    // operations of the shared arithmetic unit
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_NEG = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_ctl_t;

    typedef struct packed {
        logic done;
        logic ov;
        logic dz;
    } alu_sts_t;

    localparam word_t WMax = {1'b0, {(WordBits-1){1'b1}}};
    localparam word_t WMin = {1'b1, {(WordBits-1){1'b0}}};

    // constant one in fixed point, clamped if not representable
    localparam word_t OneQ = (FracBits >= WordBits - 1) ? WMax :
                             word_t'(64'd1 << FracBits);

endpackage

[hw/rtl/dna_alu.sv]
// Shared saturating unit: add, sub, negate computed combinationally; multiply by a
// 16x16 partial-product sequence; divide by a restoring bit-serial loop.
module dna_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  dna_pkg::alu_ctl_t ctl,
    input  dna_pkg::word_t    a,
    input  dna_pkg::word_t    b,
    output dna_pkg::word_t    y,
    output dna_pkg::alu_sts_t sts
);
    import dna_pkg::*;

    localparam int MagBits = WordBits;
    localparam int ProdBits = 2 * WordBits;
    localparam int HalfBits = WordBits / 2;
    localparam int NumBits = WordBits + FracBits;
    localparam int CntBits = $clog2(NumBits + 1);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} st_t;

    st_t                  st_reg;
    op_t                  op_reg;
    logic                 neg_reg;
    logic [MagBits-1:0]   ma_reg, mb_reg;
    logic [ProdBits-1:0]  acc_reg;
    logic [1:0]           pp_reg;
    logic [NumBits-1:0]   num_reg;
    logic [MagBits:0]     rem_reg;
    logic [CntBits-1:0]   cnt_reg;
    word_t                y_reg;
    logic                 done_reg, ov_reg, dz_reg;

    logic [MagBits-1:0]   mag_a, mag_b;
    logic signed [WordBits:0] sum_w;
    word_t                sat_sum;
    logic                 sum_ov;
    logic [HalfBits-1:0]  pa, pb;
    logic [WordBits-1:0]  pprod;
    logic [MagBits:0]     rem_sh, rem_sub;
    logic                 q_bit;
    logic                 rnd_up;
    logic [ProdBits-1:0]  fin_mag;
    logic [ProdBits-1:0]  prod_rnd;
    word_t                fit_w;
    logic                 fit_ov;

    assign mag_a = a[WordBits-1] ? MagBits'(-a) : MagBits'(a);
    assign mag_b = b[WordBits-1] ? MagBits'(-b) : MagBits'(b);

    // combinational add/sub/negate with saturation
    always_comb begin
        unique case (ctl.op)
            OP_ADD:  sum_w = {a[WordBits-1], a} + {b[WordBits-1], b};
            OP_SUB:  sum_w = {a[WordBits-1], a} - {b[WordBits-1], b};
            default: sum_w = -{a[WordBits-1], a};
        endcase
        sum_ov  = sum_w[WordBits] != sum_w[WordBits-1];
        sat_sum = sum_ov ? (sum_w[WordBits] ? WMin : WMax) : word_t'(sum_w);
    end

    // partial product: pp index picks halves
    always_comb begin
        pa = pp_reg[0] ? ma_reg[MagBits-1 -: HalfBits] : ma_reg[HalfBits-1:0];
        pb = pp_reg[1] ? mb_reg[MagBits-1 -: HalfBits] : mb_reg[HalfBits-1:0];
        pprod = WordBits'(pa) * WordBits'(pb);
    end

    // restoring division step
    always_comb begin
        rem_sh  = {rem_reg[MagBits-1:0], num_reg[NumBits-1]};
        rem_sub = rem_sh - {1'b0, mb_reg};
        q_bit   = rem_sh >= {1'b0, mb_reg};
    end

    // rounding and fit of the magnitude to a signed word
    always_comb begin
        prod_rnd = (acc_reg + (ProdBits'(1) << (FracBits - 1))) >> FracBits;
        // quotient held in num_reg; round up if rem >= d - rem
        rnd_up = rem_reg >= ({1'b0, mb_reg} - rem_reg);
        if (op_reg == OP_MUL) begin
            fin_mag = prod_rnd;
        end else begin
            fin_mag = ProdBits'(num_reg) + ProdBits'(rnd_up);
        end
        fit_ov = 1'b0;
        if (neg_reg) begin
            if (fin_mag > (ProdBits'(1) << (WordBits - 1))) begin
                fit_w = WMin; fit_ov = 1'b1;
            end else begin
                fit_w = word_t'(-fin_mag);
            end
        end else begin
            if (fin_mag > ProdBits'(WMax)) begin
                fit_w = WMax; fit_ov = 1'b1;
            end else begin
                fit_w = word_t'(fin_mag);
            end
        end
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            unique case (st_reg)
                S_IDLE: begin
                    if (ctl.start) begin
                        op_reg  <= ctl.op;
                        neg_reg <= a[WordBits-1] ^ b[WordBits-1];
                        ma_reg  <= mag_a;
                        mb_reg  <= mag_b;
                        unique case (ctl.op)
                            OP_MUL: begin
                                ov_reg  <= 1'b0;
                                dz_reg  <= 1'b0;
                                acc_reg <= '0;
                                pp_reg  <= '0;
                                st_reg  <= S_MUL;
                            end
                            OP_DIV: begin
                                ov_reg <= 1'b0;
                                if (mag_b == '0) begin
                                    y_reg    <= a[WordBits-1] ? WMin : WMax;
                                    dz_reg   <= 1'b1;
                                    done_reg <= 1'b1;
                                end else begin
                                    dz_reg  <= 1'b0;
                                    num_reg <= {mag_a, FracBits'(0)};
                                    rem_reg <= '0;
                                    cnt_reg <= CntBits'(NumBits);
                                    st_reg  <= S_DIV;
                                end
                            end
                            default: begin
                                y_reg    <= sat_sum;
                                ov_reg   <= sum_ov;
                                dz_reg   <= 1'b0;
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    acc_reg <= acc_reg + (ProdBits'(pprod) <<
                               (HalfBits * (32'(pp_reg[0]) + 32'(pp_reg[1]))));
                    pp_reg  <= pp_reg + 2'd1;
                    if (pp_reg == 2'd3) st_reg <= S_FIN;
                end
                S_DIV: begin
                    rem_reg <= q_bit ? rem_sub : rem_sh;
                    num_reg <= {num_reg[NumBits-2:0], q_bit};
                    cnt_reg <= cnt_reg - CntBits'(1);
                    if (cnt_reg == CntBits'(1)) st_reg <= S_FIN;
                end
                default: begin
                    y_reg    <= fit_w;
                    ov_reg   <= fit_ov;
                    done_reg <= 1'b1;
                    st_reg   <= S_IDLE;
                end
            endcase
        end
    end

    assign y = y_reg;
    assign sts = '{done: done_reg, ov: ov_reg, dz: dz_reg};

endmodule

[hw/rtl/dna_seq.sv]
// Sequencer: walks the micro-steps of each function through the shared unit.
module dna_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  dna_pkg::in_item_t  item,
    output logic               busy,
    output logic               done,
    output dna_pkg::out_item_t result,
    output dna_pkg::alu_ctl_t  ctl,
    output dna_pkg::word_t     opa,
    output dna_pkg::word_t     opb,
    input  dna_pkg::word_t     alu_y,
    input  dna_pkg::alu_sts_t  sts
);
    import dna_pkg::*;

    typedef enum logic [1:0] {Q_IDLE, Q_ISSUE, Q_WAIT} qs_t;

    // micro-steps; power loop reuses MUL-style steps
    typedef enum logic [4:0] {
        U_VAL, U_DER, U_M1, U_M2, U_DV1, U_DV2, U_RSUB, U_RADD,
        U_CN, U_NEG, U_CD1, U_CD2,
        U_PCHK, U_PV, U_PD1, U_PD2, U_PDS, U_XV, U_XD1, U_XD2, U_XDS, U_END
    } ustep_t;

    qs_t     qs_reg;
    ustep_t  u_reg;
    func_t   fn_reg;
    word_t   fv_reg, fd_reg, gv_reg, gd_reg, c_reg;
    word_t   t1_reg, t2_reg, rv_reg, rd_reg;
    word_t   pv_reg, pd_reg;
    logic [ExpBits-1:0] e_reg;
    logic    ov_reg, dz_reg, done_reg, inv_reg;
    logic    recip;
    op_t     op_sel;
    word_t   a_sel, b_sel;
    ustep_t  u_after;

    // power with a negative exponent starts with the reciprocal
    assign recip = (func_t'(item.func) == FUNC_POW) && item.exponent[ExpBits-1];

    // operand and op selection per micro-step
    always_comb begin
        op_sel = OP_ADD; a_sel = fv_reg; b_sel = gv_reg;
        unique case (u_reg)
            U_VAL: begin
                unique case (fn_reg)
                    FUNC_ADD:  begin op_sel = OP_ADD; a_sel = fv_reg; b_sel = gv_reg; end
                    FUNC_ADDC: begin op_sel = OP_ADD; a_sel = fv_reg; b_sel = c_reg; end
                    FUNC_SUB:  begin op_sel = OP_SUB; a_sel = fv_reg; b_sel = gv_reg; end
                    FUNC_MUL:  begin op_sel = OP_MUL; a_sel = fv_reg; b_sel = gv_reg; end
                    FUNC_MULC: begin op_sel = OP_MUL; a_sel = fv_reg; b_sel = c_reg; end
                    FUNC_DIV:  begin op_sel = OP_DIV; a_sel = fv_reg; b_sel = gv_reg; end
                    default:   begin op_sel = OP_DIV; a_sel = c_reg;  b_sel = fv_reg; end
                endcase
            end
            U_DER: begin
                unique case (fn_reg)
                    FUNC_ADD:  begin op_sel = OP_ADD; a_sel = fd_reg; b_sel = gd_reg; end
                    FUNC_SUB:  begin op_sel = OP_SUB; a_sel = fd_reg; b_sel = gd_reg; end
                    default:   begin op_sel = OP_MUL; a_sel = fd_reg; b_sel = c_reg; end
                endcase
            end
            U_M1:   begin op_sel = OP_MUL; a_sel = fd_reg; b_sel = gv_reg; end
            U_M2:   begin op_sel = OP_MUL; a_sel = gd_reg; b_sel = fv_reg; end
            U_RADD: begin op_sel = OP_ADD; a_sel = t1_reg; b_sel = t2_reg; end
            U_RSUB: begin op_sel = OP_SUB; a_sel = t1_reg; b_sel = t2_reg; end
            U_DV1:  begin op_sel = OP_DIV; a_sel = t1_reg; b_sel = gv_reg; end
            U_DV2:  begin op_sel = OP_DIV; a_sel = t1_reg; b_sel = gv_reg; end
            U_CN:   begin op_sel = OP_MUL; a_sel = c_reg;  b_sel = fd_reg; end
            U_NEG:  begin op_sel = OP_NEG; a_sel = t1_reg; b_sel = t1_reg; end
            U_CD1:  begin op_sel = OP_DIV; a_sel = t1_reg; b_sel = fv_reg; end
            U_CD2:  begin op_sel = OP_DIV; a_sel = t1_reg; b_sel = fv_reg; end
            U_PV:   begin op_sel = OP_MUL; a_sel = pv_reg; b_sel = fv_reg; end
            U_PD1:  begin op_sel = OP_MUL; a_sel = pd_reg; b_sel = fv_reg; end
            U_PD2:  begin op_sel = OP_MUL; a_sel = fd_reg; b_sel = pv_reg; end
            U_PDS:  begin op_sel = OP_ADD; a_sel = t1_reg; b_sel = t2_reg; end
            U_XV:   begin op_sel = OP_MUL; a_sel = fv_reg; b_sel = fv_reg; end
            U_XD1:  begin op_sel = OP_MUL; a_sel = fd_reg; b_sel = fv_reg; end
            U_XD2:  begin op_sel = OP_MUL; a_sel = fd_reg; b_sel = fv_reg; end
            U_XDS:  begin op_sel = OP_ADD; a_sel = t1_reg; b_sel = t2_reg; end
            default: begin op_sel = OP_ADD; a_sel = fv_reg; b_sel = gv_reg; end
        endcase
    end

    // the power loop at its head: end at a zero exponent, multiply if low bit set, else shift and square
    always_comb begin
        if (e_reg == '0)          u_after = U_END;
        else if (e_reg[0])        u_after = U_PV;
        else                      u_after = U_XV;
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            qs_reg <= Q_IDLE;
        end else begin
            unique case (qs_reg)
                Q_IDLE: begin
                    if (start) begin
                        fn_reg <= func_t'(item.func);
                        fv_reg <= item.f_value;
                        fd_reg <= item.f_deriv;
                        gv_reg <= item.g_value;
                        gd_reg <= item.g_deriv;
                        // reciprocal first: c = one, then c/x
                        c_reg  <= recip ? OneQ : item.const_in;
                        e_reg  <= item.exponent[ExpBits-1] ? ExpBits'(-item.exponent)
                                                           : ExpBits'(item.exponent);
                        ov_reg <= 1'b0;
                        dz_reg <= 1'b0;
                        pv_reg <= OneQ;
                        pd_reg <= '0;
                        inv_reg <= recip;
                        if (func_t'(item.func) == FUNC_POW) begin
                            u_reg  <= recip ? U_VAL : U_PCHK;
                            qs_reg <= Q_ISSUE;
                        end else if (func_t'(item.func) == FUNC_MUL ||
                                     func_t'(item.func) == FUNC_DIV) begin
                            u_reg  <= U_M1;
                            qs_reg <= Q_ISSUE;
                        end else begin
                            u_reg  <= U_VAL;
                            qs_reg <= Q_ISSUE;
                        end
                    end
                end
                Q_ISSUE: begin
                    if (u_reg == U_PCHK) begin
                        u_reg <= u_after;
                        // a clear low bit is consumed here, before squaring
                        if (u_after == U_XV) e_reg <= e_reg >> 1;
                        if (u_after == U_END) begin
                            rv_reg   <= pv_reg;
                            rd_reg   <= pd_reg;
                            done_reg <= 1'b1;
                            qs_reg   <= Q_IDLE;
                        end
                    end else if (u_reg == U_END) begin
                        done_reg <= 1'b1;
                        qs_reg   <= Q_IDLE;
                    end else begin
                        qs_reg <= Q_WAIT;
                    end
                end
                default: begin
                    if (sts.done) begin
                        ov_reg <= ov_reg | sts.ov;
                        dz_reg <= dz_reg | sts.dz;
                        qs_reg <= Q_ISSUE;
                        unique case (u_reg)
                            U_M1: begin t1_reg <= alu_y; u_reg <= U_M2; end
                            U_M2: begin
                                t2_reg <= alu_y;
                                u_reg  <= (fn_reg == FUNC_DIV) ? U_RSUB : U_RADD;
                            end
                            U_RADD: begin rd_reg <= alu_y; u_reg <= U_VAL; end
                            U_RSUB: begin t1_reg <= alu_y; u_reg <= U_DV1; end
                            U_DV1:  begin t1_reg <= alu_y; u_reg <= U_DV2; end
                            U_DV2:  begin rd_reg <= alu_y; u_reg <= U_VAL; end
                            U_VAL: begin
                                rv_reg <= alu_y;
                                unique case (fn_reg)
                                    FUNC_ADD, FUNC_SUB, FUNC_MULC: u_reg <= U_DER;
                                    FUNC_ADDC: begin rd_reg <= fd_reg; u_reg <= U_END; end
                                    FUNC_CDIV, FUNC_POW: u_reg <= U_CN;
                                    default: u_reg <= U_END;
                                endcase
                            end
                            U_DER: begin rd_reg <= alu_y; u_reg <= U_END; end
                            U_CN: begin t1_reg <= alu_y; u_reg <= U_NEG; end
                            // -(c f'): negate through the adder
                            U_NEG: begin t1_reg <= alu_y; u_reg <= U_CD1; end
                            U_CD1: begin t1_reg <= alu_y; u_reg <= U_CD2; end
                            U_CD2: begin
                                if (inv_reg) begin
                                    fv_reg <= rv_reg;
                                    fd_reg <= alu_y;
                                    inv_reg <= 1'b0;
                                    u_reg  <= U_PCHK;
                                end else begin
                                    rd_reg <= alu_y;
                                    u_reg  <= U_END;
                                end
                            end
                            U_PV:  begin t1_reg <= alu_y; u_reg <= U_PD1; end
                            U_PD1: begin t2_reg <= alu_y; u_reg <= U_PD2; end
                            U_PD2: begin
                                pv_reg <= t1_reg;
                                t1_reg <= t2_reg;
                                t2_reg <= alu_y;
                                u_reg  <= U_PDS;
                            end
                            U_PDS: begin
                                pd_reg <= alu_y;
                                e_reg  <= e_reg >> 1;
                                u_reg  <= (e_reg[ExpBits-1:1] == '0) ? U_PCHK : U_XV;
                            end
                            U_XV:  begin t1_reg <= alu_y; u_reg <= U_XD1; end
                            U_XD1: begin t2_reg <= alu_y; u_reg <= U_XD2; end
                            U_XD2: begin
                                fv_reg <= t1_reg;
                                t1_reg <= t2_reg;
                                t2_reg <= alu_y;
                                u_reg  <= U_XDS;
                            end
                            U_XDS: begin
                                fd_reg <= alu_y;
                                u_reg  <= U_PCHK;
                            end
                            default: u_reg <= U_END;
                        endcase
                    end
                end
            endcase
        end
    end

    always_comb begin
        ctl.start = (qs_reg == Q_ISSUE && u_reg != U_PCHK && u_reg != U_END);
        ctl.op    = op_sel;
        opa       = a_sel;
        opb       = b_sel;
    end

    assign busy   = qs_reg != Q_IDLE;
    assign done   = done_reg;
    assign result = '{res_value: rv_reg, res_deriv: rd_reg,
                      overflow: ov_reg, div_zero: dz_reg};

endmodule

[hw/rtl/dual_number_arith_unit.sv]
// Value and derivative for add-constant, add/sub, scale, product, quotient, constant over
// dual and power, which squares and multiplies over the bits of |n|, after a reciprocal
// for n < 0. A division takes 48 restoring steps; a zero divisor skips them, saturates
// and sets div_zero. One item at a time: s_ready is low from the transfer until the
// result is taken. Synchronous aresetn clears control.
module dual_number_arith_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dna_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dna_pkg::out_item_t m_data
);
    import dna_pkg::*;

    alu_ctl_t  ctl;
    alu_sts_t  sts;
    word_t     opa, opb, alu_y;
    logic      busy, done;
    out_item_t result;
    logic      m_valid_reg;
    out_item_t m_data_reg;

    dna_seq u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .start(s_valid && s_ready), .item(s_data),
        .busy(busy), .done(done), .result(result),
        .ctl(ctl), .opa(opa), .opb(opb), .alu_y(alu_y), .sts(sts)
    );

    dna_alu u_alu (
        .aclk(aclk), .aresetn(aresetn),
        .ctl(ctl), .a(opa), .b(opb), .y(alu_y), .sts(sts)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= result;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign s_ready = !busy && !done && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hw/rtl/dna_checker.sv]
module dna_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input dna_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input dna_pkg::out_item_t m_data
);
    import dna_pkg::*;

    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no new item right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted two items back to back");

    // no valid div_zero sampled after an accepted add
    a_addz: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == FUNC_ADD |=> ##3 !(m_valid && m_data.div_zero))
        else $error("div_zero on add");

    // not valid after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("valid after reset");

endmodule

bind dual_number_arith_unit dna_checker u_dna_checker (.*);
